@@ rtl/core/kfs_pkg.sv @@
// ----------------------------------------------------------------------------
// Keyed FIFO with search: shared definitions
// Sizes, operation and status codes, and the command and entry formats
// used by the front end, the back end and the top level.
// ----------------------------------------------------------------------------
package kfs_pkg;

   // Queue geometry.
   localparam int QUEUE_DEPTH = 16;
   localparam int KEY_BITS    = 16;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Port field widths.
   localparam int MODE_BITS   = 2;
   localparam int IN_KEY_BITS = 16;
   localparam int WORD_BITS   = 64;
   localparam int COUNT_BITS  = 5;
   localparam int STATUS_BITS = 2;

   // Command queue between the front and back ends.
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

   // Codes of the mode field.
   localparam logic [MODE_BITS-1:0] MODE_PUSH   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_POP    = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_SEARCH = 2'd2;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_POP,
      OP_SEARCH,
      OP_NOP
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      BK_IDLE,
      BK_SEARCH
   } bk_state_type;

   // One classified command as it waits in the command queue.
   typedef struct packed {
      op_type                 op;
      logic [KEY_BITS-1:0]    key;
      logic [WORD_BITS-1:0]   value_a;
      logic [WORD_BITS-1:0]   value_b;
   } cmd_type;

   // One stored queue entry.
   typedef struct packed {
      logic [KEY_BITS-1:0]    key;
      logic [WORD_BITS-1:0]   value_a;
      logic [WORD_BITS-1:0]   value_b;
   } entry_type;

   // Advance a queue pointer with wrap at the queue depth.
   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + 1'b1;
      end
      return n;
   endfunction

endpackage

@@ rtl/core/kfs_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/kfs_front.sv @@
// ----------------------------------------------------------------------------
// Keyed FIFO front end
// Accepts request beats, decodes the mode into an operation and holds the
// commands in a short queue until the back end takes them.
// ----------------------------------------------------------------------------
module kfs_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [kfs_pkg::MODE_BITS-1:0]    req_mode,
   input  logic [kfs_pkg::IN_KEY_BITS-1:0]  req_key,
   input  logic [kfs_pkg::WORD_BITS-1:0]    req_value_a,
   input  logic [kfs_pkg::WORD_BITS-1:0]    req_value_b,
   output logic                             cmd_valid,
   output kfs_pkg::cmd_type                 cmd,
   input  logic                             cmd_pop
);

   kfs_pkg::cmd_type                  cmdq_ff [kfs_pkg::CMDQ_DEPTH];
   logic [kfs_pkg::CMDQ_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [kfs_pkg::CMDQ_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [kfs_pkg::CMDQ_CNT_W-1:0]    fill_ff, fill_in;
   kfs_pkg::cmd_type                  new_cmd;
   logic                              push;

   // Decode the request beat into a command.
   always_comb begin
      new_cmd.key     = kfs_pkg::KEY_BITS'(req_key);
      new_cmd.value_a = req_value_a;
      new_cmd.value_b = req_value_b;
      case (req_mode)
         kfs_pkg::MODE_PUSH:   new_cmd.op = kfs_pkg::OP_PUSH;
         kfs_pkg::MODE_POP:    new_cmd.op = kfs_pkg::OP_POP;
         kfs_pkg::MODE_SEARCH: new_cmd.op = kfs_pkg::OP_SEARCH;
         default:              new_cmd.op = kfs_pkg::OP_NOP;
      endcase
   end

   assign req_ready = (fill_ff != kfs_pkg::CMDQ_CNT_W'(kfs_pkg::CMDQ_DEPTH));
   assign push      = req_valid && req_ready;
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = cmdq_ff[rd_ptr_ff];

   // Queue pointers and fill level.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         if (wr_ptr_ff == kfs_pkg::CMDQ_PTR_W'(kfs_pkg::CMDQ_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end
      if (cmd_pop) begin
         if (rd_ptr_ff == kfs_pkg::CMDQ_PTR_W'(kfs_pkg::CMDQ_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
      end
      if (push && !cmd_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Command storage.
   always_ff @(posedge clock) begin
      if (push) begin
         cmdq_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

@@ rtl/core/kfs_back.sv @@
// ----------------------------------------------------------------------------
// Keyed FIFO back end
// Owns the entry store, the head and tail pointers and the entry count.
// Carries out push, pop and search commands and holds the response beat.
// ----------------------------------------------------------------------------
module kfs_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   input  kfs_pkg::cmd_type                 cmd,
   output logic                             cmd_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_found,
   output logic [kfs_pkg::WORD_BITS-1:0]    rsp_out_a,
   output logic [kfs_pkg::WORD_BITS-1:0]    rsp_out_b,
   output logic [kfs_pkg::COUNT_BITS-1:0]   rsp_count,
   output logic [kfs_pkg::STATUS_BITS-1:0]  rsp_status
);

   kfs_pkg::bk_state_type             state_ff, state_in;
   logic [kfs_pkg::PTR_W-1:0]         head_ff, head_in;
   logic [kfs_pkg::PTR_W-1:0]         tail_ff, tail_in;
   logic [kfs_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic [kfs_pkg::PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [kfs_pkg::CNT_W-1:0]         left_ff, left_in;
   logic [kfs_pkg::KEY_BITS-1:0]      key_ff, key_in;

   logic                              valid_ff, valid_in;
   logic                              found_ff, found_in;
   logic [kfs_pkg::WORD_BITS-1:0]     out_a_ff, out_a_in;
   logic [kfs_pkg::WORD_BITS-1:0]     out_b_ff, out_b_in;
   logic [kfs_pkg::CNT_W-1:0]         count_ff, count_in;
   kfs_pkg::status_type               status_ff, status_in;

   logic                              wr_en;
   kfs_pkg::entry_type                wr_entry;
   logic                              rd_en;
   logic [kfs_pkg::PTR_W-1:0]         rd_addr;
   logic [$bits(kfs_pkg::entry_type)-1:0] rd_bits;
   kfs_pkg::entry_type                rd_entry;
   logic                              slot_free;

   // Entry store: key and both data words side by side.
   kfs_ram #(
      .WIDTH ($bits(kfs_pkg::entry_type)),
      .DEPTH (kfs_pkg::QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   assign rd_entry         = kfs_pkg::entry_type'(rd_bits);
   assign wr_entry.key     = cmd.key;
   assign wr_entry.value_a = cmd.value_a;
   assign wr_entry.value_b = cmd.value_b;

   // The response slot frees up when its beat is taken.
   assign slot_free = !valid_ff || rsp_ready;

   // Command execution and search walk.
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      cnt_in    = cnt_ff;
      rd_ptr_in = rd_ptr_ff;
      left_in   = left_ff;
      key_in    = key_ff;
      valid_in  = valid_ff && !rsp_ready;
      found_in  = found_ff;
      out_a_in  = out_a_ff;
      out_b_in  = out_b_ff;
      count_in  = count_ff;
      status_in = status_ff;
      cmd_pop   = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = rd_ptr_ff;

      case (state_ff)
         kfs_pkg::BK_IDLE: begin
            if (cmd_valid && slot_free) begin
               cmd_pop   = 1'b1;
               found_in  = 1'b0;
               out_a_in  = '0;
               out_b_in  = '0;
               status_in = kfs_pkg::ST_OK;
               valid_in  = 1'b1;
               case (cmd.op)
                  kfs_pkg::OP_PUSH: begin
                     if (cnt_ff == kfs_pkg::FULL_COUNT) begin
                        status_in = kfs_pkg::ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        tail_in = kfs_pkg::next_ptr(tail_ff);
                        cnt_in  = cnt_ff + 1'b1;
                     end
                  end
                  kfs_pkg::OP_POP: begin
                     if (cnt_ff == '0) begin
                        status_in = kfs_pkg::ST_EMPTY;
                     end else begin
                        head_in = kfs_pkg::next_ptr(head_ff);
                        cnt_in  = cnt_ff - 1'b1;
                     end
                  end
                  kfs_pkg::OP_SEARCH: begin
                     // An empty queue answers at once; otherwise start the walk.
                     if (cnt_ff != '0) begin
                        valid_in  = 1'b0;
                        rd_en     = 1'b1;
                        rd_addr   = head_ff;
                        rd_ptr_in = kfs_pkg::next_ptr(head_ff);
                        left_in   = cnt_ff;
                        key_in    = cmd.key;
                        state_in  = kfs_pkg::BK_SEARCH;
                     end
                  end
                  default: begin
                  end
               endcase
               count_in = cnt_in;
            end
         end
         kfs_pkg::BK_SEARCH: begin
            // Compare the entry read last cycle and fetch the next one.
            rd_en     = 1'b1;
            rd_ptr_in = kfs_pkg::next_ptr(rd_ptr_ff);
            left_in   = left_ff - 1'b1;
            if (rd_entry.key == key_ff) begin
               found_in = 1'b1;
               out_a_in = rd_entry.value_a;
               out_b_in = rd_entry.value_b;
            end
            if (left_ff == kfs_pkg::CNT_W'(1)) begin
               valid_in = 1'b1;
               count_in = cnt_ff;
               state_in = kfs_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = kfs_pkg::BK_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kfs_pkg::BK_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   // Walk state and response payload.
   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      left_ff   <= left_in;
      key_ff    <= key_in;
      found_ff  <= found_in;
      out_a_ff  <= out_a_in;
      out_b_ff  <= out_b_in;
      count_ff  <= count_in;
      status_ff <= status_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_found  = found_ff;
   assign rsp_out_a  = out_a_ff;
   assign rsp_out_b  = out_b_ff;
   assign rsp_count  = kfs_pkg::COUNT_BITS'(count_ff);
   assign rsp_status = status_ff;

`ifndef SYNTH
   // The entry count never passes the queue depth.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= kfs_pkg::FULL_COUNT)
      else $error("entry count above queue depth");

   // An empty queue has its head and tail together.
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty queue with head and tail apart");

   // No response beat is shown while a search walk is running.
   a_walk_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kfs_pkg::BK_SEARCH) |-> !valid_ff)
      else $error("response valid during search walk");

   // A dropped push reports a full queue.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && status_ff == kfs_pkg::ST_FULL) |-> (count_ff == kfs_pkg::FULL_COUNT))
      else $error("full status with queue not full");
`endif

endmodule

@@ rtl/core/keyed_fifo_with_search_core.sv @@
// ----------------------------------------------------------------------------
// Keyed FIFO with search
// Bounded FIFO of key plus two data word entries, with push, pop and
// newest-match search by key. One response beat per request beat.
//
//   Channel  Direction  Handshake            Payload
//   req_     in         req_valid/req_ready  mode, key, value_a, value_b
//   rsp_     out        rsp_valid/rsp_ready  found, out_a, out_b, count, status
//
// Push, pop and unused modes are carried out in the back end once dequeued.
// A search walks the held entries oldest to newest through the single
// read port of the entry store.
// A two-beat command queue keeps accepting requests while a response waits.
// Synchronous reset empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module keyed_fifo_with_search_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [kfs_pkg::MODE_BITS-1:0]    req_mode,
   input  logic [kfs_pkg::IN_KEY_BITS-1:0]  req_key,
   input  logic [kfs_pkg::WORD_BITS-1:0]    req_value_a,
   input  logic [kfs_pkg::WORD_BITS-1:0]    req_value_b,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_found,
   output logic [kfs_pkg::WORD_BITS-1:0]    rsp_out_a,
   output logic [kfs_pkg::WORD_BITS-1:0]    rsp_out_b,
   output logic [kfs_pkg::COUNT_BITS-1:0]   rsp_count,
   output logic [kfs_pkg::STATUS_BITS-1:0]  rsp_status
);

   logic             cmd_valid;
   kfs_pkg::cmd_type cmd;
   logic             cmd_pop;

   // Request decode and command queue.
   kfs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .req_key     (req_key),
      .req_value_a (req_value_a),
      .req_value_b (req_value_b),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   // Entry store, pointers and response register.
   kfs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_found  (rsp_found),
      .rsp_out_a  (rsp_out_a),
      .rsp_out_b  (rsp_out_b),
      .rsp_count  (rsp_count),
      .rsp_status (rsp_status)
   );

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Keyed FIFO with search: self-checking testbench
// Requests go in and responses come out on valid/ready channels. Both sides
// stall at random, except over one long steady stretch. A short table of
// directed requests covers the empty and full queue, every mode and the
// newest-match rule. A long run of random requests follows, in phases that
// alternate between filling and draining the queue. A behavioral copy of the
// queue predicts each response, and every response beat is checked field by
// field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

   localparam real HALF_PERIOD   = 6.0;
   localparam int  RESET_CYCLES  = 7;
   localparam int  RANDOM_ITEMS  = 1200;
   localparam int  STALL_PERCENT = 34;
   localparam int  DRAIN_CYCLES  = 2 * kfs_pkg::QUEUE_DEPTH + 8;
   localparam logic [kfs_pkg::MODE_BITS-1:0] MODE_NONE = 2'd3;
   localparam logic [kfs_pkg::WORD_BITS-1:0] ALL_ONES  = '1;

   // One response beat as the checker sees it.
   typedef struct packed {
      logic                             found;
      logic [kfs_pkg::WORD_BITS-1:0]    out_a;
      logic [kfs_pkg::WORD_BITS-1:0]    out_b;
      logic [kfs_pkg::COUNT_BITS-1:0]   count;
      kfs_pkg::status_type              status;
   } reply_type;

   // One row of the directed table; repeats sends the same beat that often.
   typedef struct {
      logic [kfs_pkg::MODE_BITS-1:0]    mode;
      logic [kfs_pkg::IN_KEY_BITS-1:0]  key;
      logic [kfs_pkg::WORD_BITS-1:0]    value_a;
      logic [kfs_pkg::WORD_BITS-1:0]    value_b;
      int                               repeats;
      bit                               typed;
      reply_type                        reply;
   } plan_row_type;

   logic                               clock       = 1'b0;
   logic                               reset       = 1'b1;
   logic                               req_valid   = 1'b0;
   logic                               req_ready;
   logic [kfs_pkg::MODE_BITS-1:0]      req_mode    = '0;
   logic [kfs_pkg::IN_KEY_BITS-1:0]    req_key     = '0;
   logic [kfs_pkg::WORD_BITS-1:0]      req_value_a = '0;
   logic [kfs_pkg::WORD_BITS-1:0]      req_value_b = '0;
   logic                               rsp_valid;
   logic                               rsp_ready   = 1'b0;
   logic                               rsp_found;
   logic [kfs_pkg::WORD_BITS-1:0]      rsp_out_a;
   logic [kfs_pkg::WORD_BITS-1:0]      rsp_out_b;
   logic [kfs_pkg::COUNT_BITS-1:0]     rsp_count;
   logic [kfs_pkg::STATUS_BITS-1:0]    rsp_status;

   // Shadow copy of the queue contents.
   logic [kfs_pkg::KEY_BITS-1:0]       held_keys   [kfs_pkg::QUEUE_DEPTH];
   logic [kfs_pkg::WORD_BITS-1:0]      held_word_a [kfs_pkg::QUEUE_DEPTH];
   logic [kfs_pkg::WORD_BITS-1:0]      held_word_b [kfs_pkg::QUEUE_DEPTH];
   int                                 head_idx    = 0;
   int                                 tail_idx    = 0;
   int                                 held_count  = 0;

   reply_type                          pending_replies [$];
   plan_row_type                       directed_plan [$];
   int                                 mismatch_count = 0;
   bit                                 steady         = 1'b0;

   keyed_fifo_with_search_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .req_key     (req_key),
      .req_value_a (req_value_a),
      .req_value_b (req_value_b),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_found   (rsp_found),
      .rsp_out_a   (rsp_out_a),
      .rsp_out_b   (rsp_out_b),
      .rsp_count   (rsp_count),
      .rsp_status  (rsp_status)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Apply one operation to the shadow queue and return the response it causes.
   function automatic reply_type apply_queue_op(
         input logic [kfs_pkg::MODE_BITS-1:0] mode,
         input logic [kfs_pkg::IN_KEY_BITS-1:0] key,
         input logic [kfs_pkg::WORD_BITS-1:0] value_a,
         input logic [kfs_pkg::WORD_BITS-1:0] value_b);
      reply_type                    r;
      logic [kfs_pkg::KEY_BITS-1:0] sought;
      int                           p;
      r = '0;
      r.status = kfs_pkg::ST_OK;
      sought = key[kfs_pkg::KEY_BITS-1:0];
      if (mode == kfs_pkg::MODE_PUSH) begin
         if (held_count >= kfs_pkg::QUEUE_DEPTH) begin
            r.status = kfs_pkg::ST_FULL;
         end else begin
            held_keys[tail_idx] = sought;
            held_word_a[tail_idx] = value_a;
            held_word_b[tail_idx] = value_b;
            tail_idx = (tail_idx + 1) % kfs_pkg::QUEUE_DEPTH;
            held_count++;
         end
      end else if (mode == kfs_pkg::MODE_POP) begin
         if (held_count == 0) begin
            r.status = kfs_pkg::ST_EMPTY;
         end else begin
            head_idx = (head_idx + 1) % kfs_pkg::QUEUE_DEPTH;
            held_count--;
         end
      end else if (mode == kfs_pkg::MODE_SEARCH) begin
         // Walk oldest to newest so the newest match is the one that sticks.
         p = head_idx;
         for (int i = 0; i < held_count; i++) begin
            if (held_keys[p] == sought) begin
               r.found = 1'b1;
               r.out_a = held_word_a[p];
               r.out_b = held_word_b[p];
            end
            p = (p + 1) % kfs_pkg::QUEUE_DEPTH;
         end
      end
      r.count = kfs_pkg::COUNT_BITS'(held_count);
      return r;
   endfunction

   function automatic plan_row_type plan_row(
         input logic [kfs_pkg::MODE_BITS-1:0] mode,
         input logic [kfs_pkg::IN_KEY_BITS-1:0] key,
         input logic [kfs_pkg::WORD_BITS-1:0] value_a,
         input logic [kfs_pkg::WORD_BITS-1:0] value_b,
         input int repeats, input bit typed,
         input logic found,
         input logic [kfs_pkg::WORD_BITS-1:0] out_a,
         input logic [kfs_pkg::WORD_BITS-1:0] out_b,
         input int count, input kfs_pkg::status_type status);
      plan_row_type row;
      row.mode = mode;
      row.key = key;
      row.value_a = value_a;
      row.value_b = value_b;
      row.repeats = repeats;
      row.typed = typed;
      row.reply.found = found;
      row.reply.out_a = out_a;
      row.reply.out_b = out_b;
      row.reply.count = kfs_pkg::COUNT_BITS'(count);
      row.reply.status = status;
      return row;
   endfunction

   // Present one request beat, hold it until accepted, then record what it
   // should produce. Typed rows replace the shadow queue's answer.
   task automatic drive_request(input logic [kfs_pkg::MODE_BITS-1:0] mode,
                                input logic [kfs_pkg::IN_KEY_BITS-1:0] key,
                                input logic [kfs_pkg::WORD_BITS-1:0] value_a,
                                input logic [kfs_pkg::WORD_BITS-1:0] value_b,
                                input bit typed, input reply_type typed_reply);
      reply_type predicted;
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < STALL_PERCENT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_mode = mode;
      req_key = key;
      req_value_a = value_a;
      req_value_b = value_b;
      do @(posedge clock); while (!req_ready);
      predicted = apply_queue_op(mode, key, value_a, value_b);
      pending_replies.push_back(typed ? typed_reply : predicted);
   endtask

   // Response side stalls at random outside the steady stretch.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = steady || ($urandom_range(0, 99) >= STALL_PERCENT);
      end
   end

   // Compare every accepted response beat with the oldest prediction.
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            $error("response beat with no request waiting");
            mismatch_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_found !== want.found) begin
               $error("found: expected %0h, got %0h", want.found, rsp_found);
               mismatch_count++;
            end
            if (rsp_out_a !== want.out_a) begin
               $error("out_a: expected %h, got %h", want.out_a, rsp_out_a);
               mismatch_count++;
            end
            if (rsp_out_b !== want.out_b) begin
               $error("out_b: expected %h, got %h", want.out_b, rsp_out_b);
               mismatch_count++;
            end
            if (rsp_count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_count);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   // Main sequence: reset, directed table, random phases, drain.
   initial begin
      plan_row_type                    row;
      logic [kfs_pkg::IN_KEY_BITS-1:0] key_pool [8];
      logic [kfs_pkg::MODE_BITS-1:0]   mode;
      logic [kfs_pkg::IN_KEY_BITS-1:0] key;
      int                              roll;
      int                              phase_left;
      bit                              filling;

      // Empty queue, unused mode, newest match, full queue.
      directed_plan.push_back(plan_row(kfs_pkg::MODE_POP, 16'h0000, '0, '0, 1, 1,
                                       0, '0, '0, 0, kfs_pkg::ST_EMPTY));
      directed_plan.push_back(plan_row(kfs_pkg::MODE_SEARCH, 16'hFFFF, '0, '0, 1, 1,
                                       0, '0, '0, 0, kfs_pkg::ST_OK));
      directed_plan.push_back(plan_row(MODE_NONE, 16'hA5A5, ALL_ONES, ALL_ONES, 1, 1,
                                       0, '0, '0, 0, kfs_pkg::ST_OK));
      directed_plan.push_back(plan_row(kfs_pkg::MODE_PUSH, 16'hFFFF, ALL_ONES, '0, 1, 1,
                                       0, '0, '0, 1, kfs_pkg::ST_OK));
      directed_plan.push_back(plan_row(kfs_pkg::MODE_PUSH, 16'h0000, '0, ALL_ONES, 1, 1,
                                       0, '0, '0, 2, kfs_pkg::ST_OK));
      directed_plan.push_back(plan_row(kfs_pkg::MODE_SEARCH, 16'hFFFF, '0, '0, 1, 1,
                                       1, ALL_ONES, '0, 2, kfs_pkg::ST_OK));
      directed_plan.push_back(plan_row(kfs_pkg::MODE_PUSH, 16'hFFFF,
                                       64'h5555_5555_5555_5555,
                                       64'hAAAA_AAAA_AAAA_AAAA, 1, 1,
                                       0, '0, '0, 3, kfs_pkg::ST_OK));
      directed_plan.push_back(plan_row(kfs_pkg::MODE_SEARCH, 16'hFFFF, '0, '0, 1, 1,
                                       1, 64'h5555_5555_5555_5555,
                                       64'hAAAA_AAAA_AAAA_AAAA, 3, kfs_pkg::ST_OK));
      directed_plan.push_back(plan_row(kfs_pkg::MODE_SEARCH, 16'h1234, '0, '0, 1, 1,
                                       0, '0, '0, 3, kfs_pkg::ST_OK));
      directed_plan.push_back(plan_row(kfs_pkg::MODE_POP, 16'h0000, '0, '0, 1, 1,
                                       0, '0, '0, 2, kfs_pkg::ST_OK));
      directed_plan.push_back(plan_row(kfs_pkg::MODE_PUSH, 16'h00FF,
                                       64'h0123_4567_89AB_CDEF,
                                       64'hFEDC_BA98_7654_3210,
                                       kfs_pkg::QUEUE_DEPTH - 2, 0,
                                       0, '0, '0, 0, kfs_pkg::ST_OK));
      directed_plan.push_back(plan_row(kfs_pkg::MODE_PUSH, 16'h8001, ALL_ONES, ALL_ONES,
                                       1, 1, 0, '0, '0, kfs_pkg::QUEUE_DEPTH,
                                       kfs_pkg::ST_FULL));
      directed_plan.push_back(plan_row(kfs_pkg::MODE_SEARCH, 16'h8001, '0, '0, 1, 1,
                                       0, '0, '0, kfs_pkg::QUEUE_DEPTH,
                                       kfs_pkg::ST_OK));
      directed_plan.push_back(plan_row(kfs_pkg::MODE_SEARCH, 16'h0000, '0, '0, 1, 1,
                                       1, '0, ALL_ONES, kfs_pkg::QUEUE_DEPTH,
                                       kfs_pkg::ST_OK));
      directed_plan.push_back(plan_row(kfs_pkg::MODE_SEARCH, 16'h00FF, '0, '0, 1, 0,
                                       0, '0, '0, 0, kfs_pkg::ST_OK));

      key_pool[0] = 16'h0000;
      key_pool[1] = 16'hFFFF;
      for (int i = 2; i < 8; i++) key_pool[i] = kfs_pkg::IN_KEY_BITS'($urandom);

      // Hold reset, then release it on a falling edge.
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table.
      foreach (directed_plan[r]) begin
         row = directed_plan[r];
         for (int n = 0; n < row.repeats; n++) begin
            drive_request(row.mode, row.key, row.value_a, row.value_b,
                          row.typed, row.reply);
         end
      end

      // Random phases that alternately fill and drain the queue, so full,
      // empty and pointer wrap come up again and again.
      filling = 1'b0;
      phase_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 500 && n < 700);
         if (phase_left == 0) begin
            filling = ~filling;
            phase_left = $urandom_range(20, 60);
         end
         phase_left--;
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            mode = MODE_NONE;
         end else if (roll < 30) begin
            mode = kfs_pkg::MODE_SEARCH;
         end else if (roll < (filling ? 85 : 45)) begin
            mode = kfs_pkg::MODE_PUSH;
         end else begin
            mode = kfs_pkg::MODE_POP;
         end
         // Mostly keys from a small pool so searches hit and repeat.
         if ($urandom_range(0, 99) < 75) begin
            key = key_pool[$urandom_range(0, 7)];
         end else begin
            key = kfs_pkg::IN_KEY_BITS'($urandom);
         end
         drive_request(mode, key, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0, '0);
      end
      steady = 1'b0;
      @(negedge clock);
      req_valid = 1'b0;

      // Wait for the last responses, then watch for stray beats.
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #(5_000_000);
      $display("Mismatches found");
      $finish;
   end

endmodule
